// ===== rtl/iole_pkg.sv =====
// Package for the indexed ordered list engine.
// Holds command and status codes, transaction structs and cell control.
// No dependencies.
package iole_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int CMD_W = 3;
  localparam int POS_W = 8;
  localparam int DATA_W = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_READ   = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_INSERT = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_e;

  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0]      status;
    logic signed [DATA_W-1:0] read_value;
    logic [COUNT_W-1:0]       count;
  } rsp_t;

  typedef struct packed {
    logic             ins;
    logic             del;
    logic [POS_W-1:0] pos;
  } cell_ctl_t;

endpackage

// ===== rtl/iole_cell.sv =====
// One storage cell of the shifting list chain.
// Takes the new value or its left neighbor on insert, its right neighbor on delete.
// Depends on iole_pkg.
module iole_cell #(
  parameter int IDX = 0
) (
  input  logic                      clk,
  input  iole_pkg::cell_ctl_t       ctl,
  input  logic [iole_pkg::DATA_W-1:0] value,
  input  logic [iole_pkg::DATA_W-1:0] left,
  input  logic [iole_pkg::DATA_W-1:0] right,
  output logic [iole_pkg::DATA_W-1:0] data,
  output logic [iole_pkg::DATA_W-1:0] rd_out
);
  import iole_pkg::*;

  localparam logic [POS_W-1:0] MY_POS = POS_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      if (MY_POS == ctl.pos) begin
        data <= value;
      end else if (MY_POS > ctl.pos) begin
        data <= left;
      end
    end else if (ctl.del && (MY_POS >= ctl.pos)) begin
      data <= right;
    end
  end

  assign rd_out = (MY_POS == ctl.pos) ? data : '0;

endmodule

// ===== rtl/indexed_ordered_list_engine.sv =====
// Indexed ordered list engine: top level.
// Command decode, entry count, result register and the row of iole_cell.
// Depends on iole_pkg and iole_cell.
//
// Usage:
//   A command transaction is taken at a rising edge with start high and busy
//   low. Commands: read, insert at head, append at tail, insert at position,
//   delete at position. Each command gives exactly one result on the next
//   cycle: done is high for one cycle with result (status, read_value, count).
//   A new command may be given every cycle while busy is low, since every cell
//   shifts or loads in the same cycle.
//   Status: done, invalid position (list unchanged; also unused commands) or full (insert refused).
//   read_value is zero except for a successful read.
//   Reset (rst, synchronous) empties the list and holds busy high for one
//   cycle; cell contents are not cleared, only the count.
//   The receiver cannot stall: a result is shown for one cycle only.
module indexed_ordered_list_engine #(
  parameter int CAPACITY = iole_pkg::CAPACITY_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  iole_pkg::req_t request,
  output logic           done,
  output iole_pkg::rsp_t result
);
  import iole_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W ? CNT_W : POS_W) + 1;

  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              accept;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  cnt_ext;
  logic              full;
  cell_ctl_t         ctl;
  logic [STATUS_W-1:0] status_next;
  logic [DATA_W-1:0] rd_any;
  logic [DATA_W-1:0] rd_next;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  assign accept  = start && !busy;
  assign pos_ext = CMP_W'(request.position);
  assign cnt_ext = CMP_W'(cnt);
  assign full    = (cnt == CNT_W'(CAPACITY));

  always_comb begin
    ctl         = '0;
    status_next = ST_BAD_POS;
    cnt_next    = cnt;
    rd_next     = '0;
    case (request.command)
      CMD_READ: begin
        if (pos_ext < cnt_ext) begin
          status_next = ST_DONE;
          rd_next     = rd_any;
        end
      end
      CMD_HEAD, CMD_TAIL: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          ctl.ins     = accept;
          ctl.pos     = (request.command == CMD_HEAD) ? '0 : POS_W'(cnt);
          cnt_next    = cnt + CNT_W'(1);
        end
      end
      CMD_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = ST_BAD_POS;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          ctl.ins     = accept;
          ctl.pos     = request.position;
          cnt_next    = cnt + CNT_W'(1);
        end
      end
      CMD_DELETE: begin
        if (pos_ext < cnt_ext) begin
          status_next = ST_DONE;
          ctl.del     = accept;
          ctl.pos     = request.position;
          cnt_next    = cnt - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_BAD_POS;
      end
    endcase
    if (request.command == CMD_READ) begin
      ctl.pos = request.position;
    end
  end

  always_comb begin
    rd_any = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_any = rd_any | cell_rd[i];
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [DATA_W-1:0] left;
    logic [DATA_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = request.value;
    end else begin : g_mid_l
      assign left = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right = cell_data[g];
    end else begin : g_mid_r
      assign right = cell_data[g+1];
    end
    iole_cell #(.IDX(g)) u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .value  (request.value),
      .left   (left),
      .right  (right),
      .data   (cell_data[g]),
      .rd_out (cell_rd[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b1;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      done <= accept;
      if (accept) begin
        cnt <= cnt_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result.status     <= status_next;
      result.read_value <= rd_next;
      result.count      <= COUNT_W'(cnt_next);
    end
  end

endmodule

// ===== rtl/iole_checker.sv =====
// Port-level checks for the indexed ordered list engine, bound to the top.
// Depends on iole_pkg and indexed_ordered_list_engine.
module iole_checker #(
  parameter int CAPACITY = iole_pkg::CAPACITY_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input iole_pkg::req_t request,
  input logic           done,
  input iole_pkg::rsp_t result
);
  import iole_pkg::*;

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy))
    else $error("result strobe does not match accepted transaction");

  a_rd_zero: assert property (@(posedge clk) disable iff (rst)
    done && $past(request.command) != CMD_READ |-> result.read_value == '0)
    else $error("nonzero read_value on a non-read command");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> result.status != 2'd3)
    else $error("undefined status code");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && result.status == ST_FULL |-> result.count == COUNT_W'(CAPACITY))
    else $error("full status with store not full");

  a_bad_cmd: assert property (@(posedge clk) disable iff (rst)
    done && $past(request.command) != CMD_READ && $past(request.command) != CMD_HEAD
    && $past(request.command) != CMD_TAIL && $past(request.command) != CMD_INSERT
    && $past(request.command) != CMD_DELETE |-> result.status == ST_BAD_POS)
    else $error("unused command not reported as ignored");

endmodule

bind indexed_ordered_list_engine iole_checker #(.CAPACITY(CAPACITY)) u_iole_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .request (request),
  .done    (done),
  .result  (result)
);

// ===== dv/tb_indexed_ordered_list_engine.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for indexed_ordered_list_engine: directed corner commands, then
// random grow/shrink/churn traffic checked against a queue-based list predictor.
// Depends on iole_pkg and the engine RTL (iole_cell included).
module tb_indexed_ordered_list_engine;
  import iole_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
  localparam int RANDOM_ITEMS = 900;

  typedef enum int {GROW, SHRINK, CHURN} drift_e;

  class list_scoreboard;
    logic signed [DATA_W-1:0] cells[$];
    rsp_t pending[$];
    int errors;

    function logic [STATUS_W-1:0] place(int pos, logic signed [DATA_W-1:0] v);
      if (pos > cells.size()) return ST_BAD_POS;
      if (cells.size() >= CAP) return ST_FULL;
      cells.insert(pos, v);
      return ST_DONE;
    endfunction

    function void note(req_t r);
      rsp_t want;
      int n;
      n = cells.size();
      want = '0;
      want.status = ST_BAD_POS;
      case (r.command)
        CMD_READ: begin
          if (r.position < n) begin
            want.read_value = cells[r.position];
            want.status = ST_DONE;
          end
        end
        CMD_HEAD:   want.status = place(0, r.value);
        CMD_TAIL:   want.status = place(n, r.value);
        CMD_INSERT: want.status = place(r.position, r.value);
        CMD_DELETE: begin
          if (r.position < n) begin
            cells.delete(r.position);
            want.status = ST_DONE;
          end
        end
        default: want.status = ST_BAD_POS;
      endcase
      want.count = COUNT_W'(cells.size());
      pending.push_back(want);
    endfunction

    function void check(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got %p", $time, got);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
      end
      if (got.read_value !== want.read_value) begin
        errors++;
        $display("%0t: read_value expected %0d got %0d", $time,
                 want.read_value, got.read_value);
      end
      if (got.count !== want.count) begin
        errors++;
        $display("%0t: count expected %0d got %0d", $time, want.count, got.count);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic done;
  req_t request;
  rsp_t result;

  list_scoreboard sb;
  int idle_pct;
  drift_e drift;

  indexed_ordered_list_engine dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) sb.check(result);
  end

  function automatic req_t mk(logic [CMD_W-1:0] c, int p, logic signed [DATA_W-1:0] v);
    req_t r;
    r.command = c;
    r.position = POS_W'(p);
    r.value = v;
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] rand_value();
    case ($urandom_range(0, 15))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return -1;
      default: return $urandom;
    endcase
  endfunction

  function automatic req_t rand_item(drift_e d, int n);
    req_t r;
    int w;
    int p;
    w = $urandom_range(0, 99);
    case (d)
      GROW:
        r.command = (w < 30) ? CMD_HEAD : (w < 55) ? CMD_TAIL : (w < 80) ? CMD_INSERT :
                    (w < 92) ? CMD_READ : (w < 97) ? CMD_DELETE : CMD_SPARE_LO;
      SHRINK:
        r.command = (w < 50) ? CMD_DELETE : (w < 75) ? CMD_READ : (w < 85) ? CMD_INSERT :
                    (w < 90) ? CMD_HEAD : (w < 97) ? CMD_TAIL : CMD_SPARE_LO;
      default:
        r.command = (w < 20) ? CMD_READ : (w < 35) ? CMD_HEAD : (w < 50) ? CMD_TAIL :
                    (w < 72) ? CMD_INSERT : (w < 96) ? CMD_DELETE : CMD_SPARE_LO;
    endcase
    if (r.command == CMD_SPARE_LO)
      r.command = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
    p = $urandom_range(0, 99);
    if (p < 75) r.position = POS_W'($urandom_range(0, n));
    else if (p < 88) r.position = POS_W'((n > 0 && p[0]) ? n - 1 : n);
    else r.position = POS_W'($urandom_range(0, 255));
    r.value = rand_value();
    return r;
  endfunction

  task automatic send(req_t r);
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
      request = $bits(req_t)'({$urandom, $urandom});
    end
    @(negedge clk);
    start = 1'b1;
    request = r;
    do @(posedge clk); while (busy);
    sb.note(r);
  endtask

  initial begin
    req_t directed[$];
    int phase_pct[4];
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    request = '0;
    idle_pct = 0;
    drift = GROW;
    phase_pct = '{0, 58, 25, 0};
    repeat (4) @(negedge clk);
    rst = 1'b0;

    directed = '{
      mk(CMD_READ, 0, 0), mk(CMD_DELETE, 0, 0), mk(CMD_INSERT, 1, 7),
      mk(CMD_SPARE_LO, 0, 1), mk(CMD_SPARE_LO + 3'd1, 0, 2), mk(CMD_SPARE_HI, 255, -1),
      mk(CMD_HEAD, 0, 32'sh8000_0000), mk(CMD_TAIL, 0, 32'sh7fff_ffff),
      mk(CMD_INSERT, 1, -1), mk(CMD_INSERT, 3, 0), mk(CMD_INSERT, 5, 9),
      mk(CMD_READ, 0, 0), mk(CMD_READ, 3, 0), mk(CMD_READ, 4, 0), mk(CMD_READ, 255, 0),
      mk(CMD_DELETE, 255, 0), mk(CMD_DELETE, 3, 0), mk(CMD_DELETE, 0, 0),
      mk(CMD_HEAD, 0, 32'sh5555_5555), mk(CMD_TAIL, 0, 32'shaaaa_aaaa),
      mk(CMD_READ, 1, 0), mk(CMD_READ, 2, 0)
    };
    foreach (directed[i]) send(directed[i]);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = phase_pct[ph];
      for (int i = 0; i < RANDOM_ITEMS / 4; i++) begin
        // keep the list sweeping between empty and full
        if (drift == GROW && sb.cells.size() == CAP && $urandom_range(0, 4) == 0)
          drift = SHRINK;
        else if (drift == SHRINK && sb.cells.size() == 0 && $urandom_range(0, 2) == 0)
          drift = GROW;
        else if ($urandom_range(0, 49) == 0)
          drift = drift_e'($urandom_range(0, 2));
        send(rand_item(drift, sb.cells.size()));
      end
    end

    @(negedge clk);
    start = 1'b0;
    for (int k = 0; k < 100 && sb.pending.size() != 0; k++) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results expected but never seen", $time, sb.pending.size());
    end
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
